[rtl/ppp_pkg.sv]
package ppp_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int ROT_W     = 21;
	localparam int ROW_W     = 3 * ROT_W;
	localparam int PROD_W    = ROT_W + DIFF_W;
	localparam int DOT_W     = PROD_W + 2;
	localparam int SCALE_W   = 32;
	localparam int HALF_W    = DOT_W / 2;
	localparam int PART_W    = HALF_W + SCALE_W;
	localparam int NUM_W     = DOT_W + SCALE_W;
	localparam int QUO_W     = 41;
	localparam int REM_W     = DOT_W;
	localparam int FIN_W     = QUO_W + 2;
	localparam int FRONT_STAGES = 3;
	localparam int DIV_STAGES   = QUO_W + 5;
	localparam int LATENCY      = FRONT_STAGES + DIV_STAGES;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 6;

	typedef enum logic [2:0] {
		REG_ROT0    = 3'd0,
		REG_ROT1    = 3'd1,
		REG_ROT2    = 3'd2,
		REG_CENTRE_X = 3'd3,
		REG_CENTRE_Y = 3'd4,
		REG_CENTRE_Z = 3'd5,
		REG_SCALES  = 3'd6,
		REG_PP      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][ROW_W-1:0]   rot;
		logic [2:0][COORD_W-1:0] centre;
		logic [SCALE_W-1:0]      scale_x;
		logic [SCALE_W-1:0]      scale_y;
		logic [COORD_W-1:0]      base_x;
		logic [COORD_W-1:0]      base_y;
	} cfg_t;

endpackage

[rtl/ppp_if.sv]
interface ppp_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source(output valid, point_x, point_y, point_z, input ready);
	modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] image_x;
	logic signed [31:0] image_y;
	logic               invalid;

	modport source(output valid, image_x, image_y, invalid, input ready);
	modport sink(input valid, image_x, image_y, invalid, output ready);
endinterface

[rtl/ppp_cfg.sv]
module ppp_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ppp_pkg::ADDR_W-1:0] paddr,
	input  logic [ppp_pkg::DATA_W-1:0] pwdata,
	output logic [ppp_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output ppp_pkg::cfg_t              cfg
);
	import ppp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_ROT0:     cfg_q.rot[0]    <= pwdata[ROW_W-1:0];
				REG_ROT1:     cfg_q.rot[1]    <= pwdata[ROW_W-1:0];
				REG_ROT2:     cfg_q.rot[2]    <= pwdata[ROW_W-1:0];
				REG_CENTRE_X: cfg_q.centre[0] <= pwdata[COORD_W-1:0];
				REG_CENTRE_Y: cfg_q.centre[1] <= pwdata[COORD_W-1:0];
				REG_CENTRE_Z: cfg_q.centre[2] <= pwdata[COORD_W-1:0];
				REG_SCALES: begin
					cfg_q.scale_x <= pwdata[SCALE_W-1:0];
					cfg_q.scale_y <= pwdata[2*SCALE_W-1:SCALE_W];
				end
				REG_PP: begin
					cfg_q.base_x <= pwdata[COORD_W-1:0];
					cfg_q.base_y <= pwdata[2*COORD_W-1:COORD_W];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ROT0:     prdata = DATA_W'(cfg_q.rot[0]);
			REG_ROT1:     prdata = DATA_W'(cfg_q.rot[1]);
			REG_ROT2:     prdata = DATA_W'(cfg_q.rot[2]);
			REG_CENTRE_X: prdata = DATA_W'(cfg_q.centre[0]);
			REG_CENTRE_Y: prdata = DATA_W'(cfg_q.centre[1]);
			REG_CENTRE_Z: prdata = DATA_W'(cfg_q.centre[2]);
			REG_SCALES:   prdata = {cfg_q.scale_y, cfg_q.scale_x};
			REG_PP:       prdata = {cfg_q.base_y, cfg_q.base_x};
			default:      prdata = '0;
		endcase
	end
endmodule

[rtl/ppp_front.sv]
module ppp_front (
	input  logic                                clk,
	input  logic                                en,
	input  ppp_pkg::cfg_t                       cfg,
	input  logic [2:0][ppp_pkg::COORD_W-1:0]    pt,
	output logic signed [ppp_pkg::DOT_W-1:0]    u,
	output logic signed [ppp_pkg::DOT_W-1:0]    v,
	output logic signed [ppp_pkg::DOT_W-1:0]    w
);
	import ppp_pkg::*;

	logic signed [DIFF_W-1:0] d_s1 [3];
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic signed [DOT_W-1:0]  dot_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				d_s1[j] <= $signed({pt[j][COORD_W-1], pt[j]})
					- $signed({cfg.centre[j][COORD_W-1], cfg.centre[j]});
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= $signed(cfg.rot[i][ROT_W*j +: ROT_W]) * d_s1[j];
				end
			end
			for (int i = 0; i < 3; i++) begin
				dot_s3[i] <= DOT_W'(prod_s2[i][0]) + DOT_W'(prod_s2[i][1])
					+ DOT_W'(prod_s2[i][2]);
			end
		end
	end

	assign u = dot_s3[0];
	assign v = dot_s3[1];
	assign w = dot_s3[2];
endmodule

[rtl/ppp_div.sv]
module ppp_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ppp_pkg::DOT_W-1:0]  num,
	input  logic signed [ppp_pkg::DOT_W-1:0]  den,
	input  logic [ppp_pkg::SCALE_W-1:0]       scale,
	input  logic [ppp_pkg::COORD_W-1:0]       base,
	input  logic                              negate,
	output logic signed [ppp_pkg::COORD_W-1:0] res,
	output logic                              flag
);
	import ppp_pkg::*;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] lo;
		logic [QUO_W-1:0] quo;
		logic [REM_W-1:0] den;
		logic             ovf;
		logic             neg;
		logic             zero;
		logic             zsgn;
	} div_stage_t;

	logic [DOT_W-1:0]   an_s4, ad_s4;
	logic               neg_s4, zero_s4, zsgn_s4;
	logic [PART_W-1:0]  plo_s5, phi_s5;
	logic [DOT_W-1:0]   ad_s5;
	logic               neg_s5, zero_s5, zsgn_s5;
	logic [NUM_W-1:0]   n_s6;
	logic [DOT_W-1:0]   ad_s6;
	logic               neg_s6, zero_s6, zsgn_s6;
	div_stage_t         st_s [QUO_W+1];
	logic signed [COORD_W-1:0] res_s;
	logic               flag_s;

	always_ff @(posedge clk) begin
		if (en) begin
			an_s4   <= num[DOT_W-1] ? DOT_W'(-num) : DOT_W'(num);
			ad_s4   <= den[DOT_W-1] ? DOT_W'(-den) : DOT_W'(den);
			neg_s4  <= (num[DOT_W-1] != den[DOT_W-1]) != negate;
			zero_s4 <= (den == '0);
			// saturation side for zero denominator
			zsgn_s4 <= num[DOT_W-1] != negate;

			plo_s5  <= an_s4[HALF_W-1:0] * scale;
			phi_s5  <= an_s4[DOT_W-1:HALF_W] * scale;
			ad_s5   <= ad_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			zsgn_s5 <= zsgn_s4;

			n_s6    <= NUM_W'(plo_s5) + (NUM_W'(phi_s5) << HALF_W);
			ad_s6   <= ad_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
			zsgn_s6 <= zsgn_s5;

			// quotient of 2^QUO_W or more is capped anyway
			st_s[0].rem  <= REM_W'(n_s6[NUM_W-1:QUO_W]);
			st_s[0].lo   <= n_s6[QUO_W-1:0];
			st_s[0].quo  <= '0;
			st_s[0].den  <= ad_s6;
			st_s[0].ovf  <= REM_W'(n_s6[NUM_W-1:QUO_W]) >= ad_s6;
			st_s[0].neg  <= neg_s6;
			st_s[0].zero <= zero_s6;
			st_s[0].zsgn <= zsgn_s6;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [REM_W:0] trial;
		logic           fits;
		div_stage_t     nxt;

		assign trial = {st_s[k].rem, st_s[k].lo[QUO_W-1]};
		assign fits  = trial >= {1'b0, st_s[k].den};

		always_comb begin
			nxt     = st_s[k];
			nxt.rem = fits ? REM_W'(trial - {1'b0, st_s[k].den}) : REM_W'(trial);
			nxt.lo  = {st_s[k].lo[QUO_W-2:0], 1'b0};
			nxt.quo = {st_s[k].quo[QUO_W-2:0], fits};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k+1] <= nxt;
			end
		end
	end

	localparam logic [QUO_W-1:0] MAG_CAP = QUO_W'(1) << (QUO_W - 1);
	localparam logic signed [FIN_W-1:0] SAT_HI = FIN_W'(2147483647);
	localparam logic signed [FIN_W-1:0] SAT_LO = ~SAT_HI;

	div_stage_t               fin;
	logic [QUO_W-1:0]         mag;
	logic signed [FIN_W-1:0]  sval, tot;

	assign fin  = st_s[QUO_W];
	assign mag  = (fin.ovf || fin.quo > MAG_CAP) ? MAG_CAP : fin.quo;
	assign sval = fin.neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
	assign tot  = sval + $signed({{(FIN_W-COORD_W){base[COORD_W-1]}}, base});

	always_ff @(posedge clk) begin
		if (en) begin
			if (fin.zero) begin
				res_s  <= fin.zsgn ? SAT_LO[COORD_W-1:0] : SAT_HI[COORD_W-1:0];
				flag_s <= 1'b1;
			end else if (tot > SAT_HI) begin
				res_s  <= SAT_HI[COORD_W-1:0];
				flag_s <= 1'b1;
			end else if (tot < SAT_LO) begin
				res_s  <= SAT_LO[COORD_W-1:0];
				flag_s <= 1'b1;
			end else begin
				res_s  <= tot[COORD_W-1:0];
				flag_s <= 1'b0;
			end
		end
	end

	assign res  = res_s;
	assign flag = flag_s;
endmodule

[rtl/pinhole_point_projection_unit.sv]
// Projects one 3D point per word onto the image plane: subtract the camera
// centre, rotate, divide the first two components by the third, scale and add
// the principal point. A new point is taken every cycle while the output is
// not stalled; the pipeline holds the rotation, then the wide product and the
// 41-stage one-bit-per-stage restoring divider, then the output register. A
// stall at the output freezes the whole pipeline. Zero depth or
// an out-of-range result saturates the coordinates and raises invalid.
// Registers are 64 bits at byte address 8*i and must be written while idle.
module pinhole_point_projection_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ppp_pkg::ADDR_W-1:0] paddr,
	input  logic [ppp_pkg::DATA_W-1:0] pwdata,
	output logic [ppp_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	ppp_in_if.sink                     pts,
	ppp_out_if.source                  img
);
	import ppp_pkg::*;

	cfg_t                      cfg;
	logic                      en;
	logic [LATENCY-1:0]        vld_q;
	logic [2:0][COORD_W-1:0]   pt;
	logic signed [DOT_W-1:0]   u, v, w;
	logic signed [COORD_W-1:0] ix, iy;
	logic                      fx, fy;

	ppp_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	// whole pipeline advances unless the output word is held
	assign en = !vld_q[LATENCY-1] || img.ready;
	assign pts.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LATENCY-2:0], pts.valid};
		end
	end

	assign pt = {pts.point_z, pts.point_y, pts.point_x};

	ppp_front u_front (
		.clk, .en, .cfg, .pt, .u, .v, .w
	);

	ppp_div u_div_x (
		.clk, .en, .num(u), .den(w), .scale(cfg.scale_x), .base(cfg.base_x),
		.negate(1'b1), .res(ix), .flag(fx)
	);

	ppp_div u_div_y (
		.clk, .en, .num(v), .den(w), .scale(cfg.scale_y), .base(cfg.base_y),
		.negate(1'b0), .res(iy), .flag(fy)
	);

	assign img.valid   = vld_q[LATENCY-1];
	assign img.image_x = ix;
	assign img.image_y = iy;
	assign img.invalid = fx || fy;
endmodule

[test/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ppp_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               inv;
	} image_word_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	ppp_in_if  pts_if();
	ppp_out_if img_if();

	pinhole_point_projection_unit u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pts(pts_if), .img(img_if)
	);

	always #5 clk = ~clk;

	// camera setup as the projector sees it
	logic [ROW_W-1:0] cam_rows [3];
	longint           cam_centre [3];
	logic [63:0]      cam_scales;
	logic [63:0]      cam_pp;

	image_word_t expected_images [$];
	int          error_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_requests = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;

	function automatic longint row_dot(input logic [ROW_W-1:0] row, input longint dv [3]);
		longint s;
		logic signed [ROT_W-1:0] e;
		s = 0;
		for (int j = 0; j < 3; j++) begin
			e = row[ROT_W*j +: ROT_W];
			s += longint'(e) * dv[j];
		end
		return s;
	endfunction

	function automatic void image_axis(input longint num, input longint den,
			input logic [31:0] scale, input bit negate, input longint base,
			output logic signed [31:0] res, inout logic flag);
		logic [127:0] an, ad, prod, q;
		longint mag, v;
		bit neg;
		if (den == 0) begin
			flag = 1'b1;
			res = ((num < 0) != negate) ? 32'sh8000_0000 : 32'sh7fff_ffff;
			return;
		end
		an = 128'(num < 0 ? -num : num);
		ad = 128'(den < 0 ? -den : den);
		prod = an * 128'(scale);
		q = prod / ad;
		mag = (q > 128'(64'd1 << 40)) ? (longint'(1) << 40) : longint'(q[63:0]);
		neg = ((num < 0) != (den < 0)) != negate;
		v = (neg ? -mag : mag) + base;
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			res = 32'sh7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			flag = 1'b1;
			res = 32'sh8000_0000;
		end else begin
			res = v[31:0];
		end
	endfunction

	function automatic image_word_t project_point(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		image_word_t r;
		longint dv [3];
		longint u, v, w;
		logic signed [31:0] bx, by;
		r.inv = 1'b0;
		dv[0] = longint'(px) - cam_centre[0];
		dv[1] = longint'(py) - cam_centre[1];
		dv[2] = longint'(pz) - cam_centre[2];
		u = row_dot(cam_rows[0], dv);
		v = row_dot(cam_rows[1], dv);
		w = row_dot(cam_rows[2], dv);
		bx = cam_pp[31:0];
		by = cam_pp[63:32];
		image_axis(u, w, cam_scales[31:0], 1'b1, longint'(bx), r.x, r.inv);
		image_axis(v, w, cam_scales[63:32], 1'b0, longint'(by), r.y, r.inv);
		return r;
	endfunction

	// expectations are formed when a point is taken, results checked as they leave
	always @(posedge clk) begin
		image_word_t e;
		if (arst_n) begin
			if (pts_if.valid && pts_if.ready)
				expected_images.push_back(project_point(pts_if.point_x, pts_if.point_y,
					pts_if.point_z));
			if (img_if.valid && img_if.ready) begin
				if (expected_images.size() == 0) begin
					$display("%0t: unexpected word x=%h y=%h invalid=%b", $time,
						img_if.image_x, img_if.image_y, img_if.invalid);
					error_count++;
				end else begin
					e = expected_images.pop_front();
					if (img_if.image_x !== e.x) begin
						$display("%0t: image_x expected %h actual %h", $time, e.x, img_if.image_x);
						error_count++;
					end
					if (img_if.image_y !== e.y) begin
						$display("%0t: image_y expected %h actual %h", $time, e.y, img_if.image_y);
						error_count++;
					end
					if (img_if.invalid !== e.inv) begin
						$display("%0t: invalid expected %b actual %b", $time, e.inv,
							img_if.invalid);
						error_count++;
					end
				end
			end
		end
	end

	// receiver: random stalls plus a long hold when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_if.ready <= 1'b0;
		end else if (hold_requests != hold_seen) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
			img_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			img_if.ready <= 1'b0;
		end else begin
			img_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((pts_if.valid && pts_if.ready) || (img_if.valid && img_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 3'b000});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ROT0: cam_rows[0] = val[ROW_W-1:0];
			REG_ROT1: cam_rows[1] = val[ROW_W-1:0];
			REG_ROT2: cam_rows[2] = val[ROW_W-1:0];
			REG_CENTRE_X: cam_centre[0] = longint'(signed'(val[31:0]));
			REG_CENTRE_Y: cam_centre[1] = longint'(signed'(val[31:0]));
			REG_CENTRE_Z: cam_centre[2] = longint'(signed'(val[31:0]));
			REG_SCALES: cam_scales = val;
			REG_PP: cam_pp = val;
			default: ;
		endcase
	endtask

	task automatic load_camera(input logic [62:0] r0, input logic [62:0] r1,
			input logic [62:0] r2, input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] cz, input logic [63:0] sc, input logic [63:0] pp);
		reg_write(REG_ROT0, {1'b0, r0});
		reg_write(REG_ROT1, {1'b0, r1});
		reg_write(REG_ROT2, {1'b0, r2});
		reg_write(REG_CENTRE_X, {{32{cx[31]}}, cx});
		reg_write(REG_CENTRE_Y, {{32{cy[31]}}, cy});
		reg_write(REG_CENTRE_Z, {{32{cz[31]}}, cz});
		reg_write(REG_SCALES, sc);
		reg_write(REG_PP, pp);
	endtask

	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			pts_if.valid <= 1'b0;
			@(posedge clk);
		end
		pts_if.valid <= 1'b1;
		pts_if.point_x <= x;
		pts_if.point_y <= y;
		pts_if.point_z <= z;
		do @(posedge clk); while (!pts_if.ready);
	endtask

	task automatic drain;
		pts_if.valid <= 1'b0;
		while (expected_images.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [62:0] near_identity_row(input int k);
		logic [2:0][ROT_W-1:0] e;
		for (int j = 0; j < 3; j++)
			e[j] = ROT_W'($urandom_range(0, 8191) - 4096);
		e[k] = e[k] + ($urandom_range(1) ? ROT_W'(21'h080000) : ROT_W'(21'h180000));
		return e;
	endfunction

	function automatic logic [31:0] rand_coord;
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($urandom_range(0, 32'h00ff_ffff)) - 32'h0080_0000;
			2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($urandom_range(0, 32'h03ff_ffff)) - 32'h0200_0000;
		endcase
	endfunction

	function automatic logic [62:0] rand_row(input int k);
		return ($urandom_range(2) == 0) ? 63'({$urandom, $urandom}) : near_identity_row(k);
	endfunction

	task automatic load_random_camera;
		logic [63:0] sc;
		sc = ($urandom_range(1)) ? {$urandom, $urandom}
			: {32'($urandom_range(1, 4000)) << 16, 32'($urandom_range(1, 4000)) << 16};
		load_camera(rand_row(0), rand_row(1), rand_row(2), rand_coord(), rand_coord(),
			rand_coord(), sc, {$urandom, $urandom});
	endtask

	task automatic test_reset_values;
		// all-zero setup: zero depth everywhere
		send_point(32'h0001_0000, 32'hffff_0000, 32'h0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
		drain();
	endtask

	task automatic test_extremes;
		load_camera({21'h080000, 21'h0, 21'h0}, {21'h0, 21'h080000, 21'h0},
			{21'h0, 21'h0, 21'h080000}, 32'h0, 32'h0, 32'h0,
			{32'd1000 << 16, 32'd1000 << 16}, {32'd240 << 16, 32'd320 << 16});
		// identity layout: entry 0 of each row in low bits
		load_camera({21'h0, 21'h0, 21'h080000}, {21'h0, 21'h080000, 21'h0},
			{21'h080000, 21'h0, 21'h0}, 32'h0, 32'h0, 32'h0,
			{32'd1000 << 16, 32'd1000 << 16}, {32'd240 << 16, 32'd320 << 16});
		send_point(32'h0001_0000, 32'h0002_0000, 32'h000a_0000);
		send_point(32'hffff_0000, 32'hfffe_0000, 32'h000a_0000);
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h0005_0000, 32'hfffb_0000, 32'h0);
		send_point(32'hfffb_0000, 32'h0005_0000, 32'h0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001);
		send_point(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_point(32'h0000_0001, 32'hffff_ffff, 32'h8000_0000);
		drain();
		// widest entries and centre at the far bound
		load_camera({21'h100000, 21'h0fffff, 21'h100000}, {21'h0fffff, 21'h100000, 21'h0fffff},
			{21'h1fffff, 21'h000001, 21'h100000}, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_7fff_ffff);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		drain();
		load_camera({63{1'b1}}, {63{1'b1}}, {63{1'b1}}, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 64'h0000_0001_0000_0001, 64'h0);
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h0003_0000, 32'h0, 32'h0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		drain();
	endtask

	task automatic test_zero_depth;
		// depth row zero: sign of numerator picks the bound, zero counts as positive
		load_camera({21'h0, 21'h0, 21'h080000}, {21'h0, 21'h080000, 21'h0}, 63'h0,
			32'h0, 32'h0, 32'h0, {32'd500 << 16, 32'd500 << 16}, 64'h0);
		send_point(32'h0001_0000, 32'hffff_0000, 32'h0);
		send_point(32'hffff_0000, 32'h0001_0000, 32'h0);
		send_point(32'h0, 32'h0, 32'h0005_0000);
		drain();
	endtask

	task automatic test_random_phase(input int n, input int s_idle, input int r_idle);
		send_idle_pct = s_idle;
		recv_stall_pct = r_idle;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				drain();
				load_random_camera();
			end
			send_point(rand_coord(), rand_coord(), rand_coord());
		end
		drain();
	endtask

	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_random_camera();
		hold_requests++;
		for (int i = 0; i < 100; i++)
			send_point(rand_coord(), rand_coord(), rand_coord());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pts_if.valid <= 1'b0;
		pts_if.point_x <= '0;
		pts_if.point_y <= '0;
		pts_if.point_z <= '0;
		cam_rows = '{default: '0};
		cam_centre = '{default: 0};
		cam_scales = '0;
		cam_pp = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_extremes();
		test_zero_depth();
		test_random_phase(130, 13, 86);
		test_random_phase(130, 86, 13);
		test_random_phase(130, 0, 0);
		test_backpressure();
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0 && expected_images.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
